// ===== rtl/dds_rgb_stream_unpacker_core_defines.svh =====
// Assertion macros shared by the DDS unpacker RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef DDS_RGB_STREAM_UNPACKER_CORE_DEFINES_SVH
`define DDS_RGB_STREAM_UNPACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DDS_UNP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define DDS_UNP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dds_unp_pkg.sv =====
// Shared types, header constants and result codes for the DDS unpacker.
// No dependencies; imported by every RTL module of the block.
package dds_unp_pkg;

	localparam int DEF_MAX_DIM = 4096;

	// Result status codes
	localparam logic [2:0] ST_PIXEL      = 3'd0;
	localparam logic [2:0] ST_NOT_DDS    = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER = 3'd2;
	localparam logic [2:0] ST_BAD_FORMAT = 3'd3;
	localparam logic [2:0] ST_BAD_DEPTH  = 3'd4;
	localparam logic [2:0] ST_TRUNCATED  = 3'd5;

	// Header word offsets (byte position of the word's first byte)
	localparam logic [6:0] OFS_SIZE     = 7'd4;
	localparam logic [6:0] OFS_HEIGHT   = 7'd12;
	localparam logic [6:0] OFS_WIDTH    = 7'd16;
	localparam logic [6:0] OFS_PF_SIZE  = 7'd76;
	localparam logic [6:0] OFS_PF_FLAGS = 7'd80;
	localparam logic [6:0] OFS_BPP      = 7'd88;
	localparam logic [6:0] OFS_RMASK    = 7'd92;
	localparam logic [6:0] OFS_GMASK    = 7'd96;
	localparam logic [6:0] OFS_BMASK    = 7'd100;
	localparam logic [6:0] OFS_AMASK    = 7'd104;
	localparam logic [6:0] HDR_LAST     = 7'd127;

	// Header field values
	localparam logic [31:0] HDR_SIZE    = 32'd124;
	localparam logic [31:0] PF_SIZE     = 32'd32;
	localparam logic [31:0] PF_RGB      = 32'h0000_0040;
	localparam logic [31:0] PF_ALPHA    = 32'h0000_0001;
	localparam logic [31:0] MASK_RED    = 32'h00FF_0000;
	localparam logic [31:0] MASK_GREEN  = 32'h0000_FF00;
	localparam logic [31:0] MASK_BLUE   = 32'h0000_00FF;
	localparam logic [31:0] MASK_ALPHA  = 32'hFF00_0000;
	localparam logic [31:0] BPP_24      = 32'd24;
	localparam logic [31:0] BPP_32      = 32'd32;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PIXELS  = 2'd1,
		PH_DISCARD = 2'd2
	} phase_t;

	typedef struct packed {
		logic magic;
		logic header;
		logic format;
		logic depth;
		logic aflag;
		logic amask;
	} check_flags_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha_out;
		logic [2:0] status;
		logic       last;
	} out_beat_t;

	// Parser result before premultiply; color is {R,G,B}
	typedef struct packed {
		logic        emit;
		logic [2:0]  status;
		logic        last;
		logic [23:0] color;
		logic [7:0]  alpha;
	} parse_res_t;

	// Magic "DDS " byte by position
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] v;
		case (pos)
			2'd0: v = 8'h44;
			2'd1: v = 8'h44;
			2'd2: v = 8'h53;
			default: v = 8'h20;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/dds_rgb_stream_unpacker_core.sv =====
// Channel | Dir | Handshake             | Beat
// src     | in  | src_valid / src_ready | in_beat_t  : data_byte, end_of_file
// pix     | out | pix_valid / pix_ready | out_beat_t : blue, green, red, alpha_out, status, last
//
// A byte waits in the input register while parser and premultiply work on it, and
// its result loads into the result register, which drives pix_valid, when the byte advances.
// One byte per cycle is sustained while pix_ready is high; bytes with no result
// leave no beat. Reset returns the parser to the header phase; no clearing pass.
// A stalled result holds; one more byte is still taken into the input register.
`include "dds_rgb_stream_unpacker_core_defines.svh"

module dds_rgb_stream_unpacker_core
	import dds_unp_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  in_beat_t  src_data,
	output logic      pix_valid,
	input  logic      pix_ready,
	output out_beat_t pix_data
);

	logic       valid_s1;
	in_beat_t   beat_s1;
	logic       out_valid_q;
	out_beat_t  out_beat_q;
	logic       advance;
	parse_res_t res;
	logic [7:0] pm_blue;
	logic [7:0] pm_green;
	logic [7:0] pm_red;
	logic       out_err;
	logic       out_dark;
	logic       out_alpha0;
	logic       full_stall;

	// Move the held byte on when the result register is free or draining
	assign advance   = valid_s1 && (!out_valid_q || pix_ready);
	assign src_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			beat_s1 <= src_data;
		end
	end

	dds_unp_parse #(
		.MAX_DIM (MAX_DIM)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.res    (res)
	);

	dds_unp_premul u_premul (
		.color (res.color),
		.alpha (res.alpha),
		.blue  (pm_blue),
		.green (pm_green),
		.red   (pm_red)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			out_beat_q.blue      <= pm_blue;
			out_beat_q.green     <= pm_green;
			out_beat_q.red       <= pm_red;
			out_beat_q.alpha_out <= res.alpha;
			out_beat_q.status    <= res.status;
			out_beat_q.last      <= res.last;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix_data  = out_beat_q;

	// Terms for the checks below
	assign out_err    = out_valid_q && (out_beat_q.status != ST_PIXEL);
	assign out_dark   = (out_beat_q.blue == 8'd0) && (out_beat_q.green == 8'd0) &&
		(out_beat_q.red == 8'd0);
	assign out_alpha0 = (out_beat_q.alpha_out == 8'd0);
	assign full_stall = valid_s1 && out_valid_q && !pix_ready;

	// Error beats close the file and carry no color
	`DDS_UNP_ASSERT_NOW(a_err_beat, out_err, out_beat_q.last && out_alpha0 && out_dark, "bad error beat")
	// Status stays within the defined codes
	`DDS_UNP_ASSERT_NOW(a_status_range, out_valid_q, out_beat_q.status <= ST_TRUNCATED, "bad status")
	// Transparent pixels premultiply to black
	`DDS_UNP_ASSERT_NOW(a_zero_alpha, out_valid_q && !out_err && out_alpha0, out_dark, "color at zero alpha")
	// Full pipeline with a stalled result must not take a byte
	`DDS_UNP_ASSERT_NOW(a_full_stall, full_stall, !src_ready, "byte accepted while pipeline is full")
	// A held byte with a stalled result stays in the input register
	`DDS_UNP_ASSERT_NEXT(a_s1_hold, full_stall, valid_s1, "held byte lost under stall")

endmodule

// ===== rtl/dds_unp_parse.sv =====
// Header parser and pixel assembler: keeps all per-file state.
// Depends on dds_unp_pkg. Result is combinational from the current beat.
module dds_unp_parse
	import dds_unp_pkg::*;
#(
	parameter int MAX_DIM = DEF_MAX_DIM
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  in_beat_t   beat,
	output parse_res_t res
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	phase_t             phase_q, phase_d;
	logic [6:0]         hdr_pos_q, hdr_pos_d;
	logic [31:0]        word_q, word_d;
	check_flags_t       flags_q, flags_d;
	logic [DIM_W-1:0]   width_q, width_d;
	logic [DIM_W-1:0]   height_q, height_d;
	logic               four_q, four_d;
	logic               alpha_q, alpha_d;
	logic [23:0]        pix_q, pix_d;
	logic [1:0]         idx_q, idx_d;
	logic [DIM_W-1:0]   col_q, col_d;
	logic [DIM_W-1:0]   row_q, row_d;

	logic [7:0]         b;
	logic               eof;
	logic [31:0]        word_next;
	logic               pos_last;
	logic               word_end;
	logic [6:0]         word_ofs;
	logic               dim_ok;
	logic [2:0]         err_code;
	logic               need_last;
	logic [DIM_W-1:0]   col_inc;
	logic [DIM_W-1:0]   row_inc;
	logic               row_done;
	logic               final_px;

	assign b         = beat.data_byte;
	assign eof       = beat.end_of_file;
	assign word_next = {b, word_q[31:8]};
	assign pos_last  = (hdr_pos_q == HDR_LAST);
	assign word_end  = (hdr_pos_q[1:0] == 2'b11);
	assign word_ofs  = {hdr_pos_q[6:2], 2'b00};
	assign dim_ok    = (word_next >= 32'd1) && (word_next <= 32'(MAX_DIM));

	// Error priority: magic, header, format, depth
	always_comb begin
		if (flags_q.magic) begin
			err_code = ST_NOT_DDS;
		end else if (flags_q.header) begin
			err_code = ST_BAD_HEADER;
		end else if (flags_q.format) begin
			err_code = ST_BAD_FORMAT;
		end else if (flags_q.depth) begin
			err_code = ST_BAD_DEPTH;
		end else begin
			err_code = ST_PIXEL;
		end
	end

	// Pixel position tracking
	assign need_last = four_q ? (idx_q == 2'd3) : (idx_q == 2'd2);
	assign col_inc   = col_q + DIM_W'(1);
	assign row_inc   = row_q + DIM_W'(1);
	assign row_done  = (col_inc >= width_q);
	assign final_px  = row_done && (row_inc >= height_q);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HEADER: begin
				if (pos_last) begin
					phase_d = (err_code != ST_PIXEL) ? PH_DISCARD : PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				if (need_last && final_px) begin
					phase_d = PH_DISCARD;
				end
			end
			PH_DISCARD: begin
				phase_d = PH_DISCARD;
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
		if (eof) begin
			phase_d = PH_HEADER;
		end
	end

	// Result for the current beat
	always_comb begin
		res        = '0;
		res.status = ST_PIXEL;
		case (phase_q)
			PH_HEADER: begin
				if (pos_last) begin
					if (err_code != ST_PIXEL) begin
						res.emit   = 1'b1;
						res.status = err_code;
						res.last   = 1'b1;
					end else if (eof) begin
						res.emit   = 1'b1;
						res.status = ST_TRUNCATED;
						res.last   = 1'b1;
					end
				end else if (eof) begin
					res.emit   = 1'b1;
					res.status = ST_NOT_DDS;
					res.last   = 1'b1;
				end
			end
			PH_PIXELS: begin
				if (!need_last) begin
					if (eof) begin
						res.emit   = 1'b1;
						res.status = ST_TRUNCATED;
						res.last   = 1'b1;
					end
				end else if (eof && !final_px) begin
					res.emit   = 1'b1;
					res.status = ST_TRUNCATED;
					res.last   = 1'b1;
				end else begin
					res.emit   = 1'b1;
					res.last   = final_px;
					res.color  = {(four_q ? pix_q[23:16] : b), pix_q[15:0]};
					res.alpha  = (four_q && alpha_q) ? b : ALPHA_OPAQUE;
				end
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
	end

	// Datapath next values
	always_comb begin
		hdr_pos_d = hdr_pos_q;
		word_d    = word_q;
		flags_d   = flags_q;
		width_d   = width_q;
		height_d  = height_q;
		four_d    = four_q;
		alpha_d   = alpha_q;
		pix_d     = pix_q;
		idx_d     = idx_q;
		col_d     = col_q;
		row_d     = row_q;
		case (phase_q)
			PH_HEADER: begin
				word_d = word_next;
				if ((hdr_pos_q[6:2] == 5'd0) && (b != magic_byte(hdr_pos_q[1:0]))) begin
					flags_d.magic = 1'b1;
				end
				if (word_end) begin
					case (word_ofs)
						OFS_SIZE: begin
							if (word_next != HDR_SIZE) flags_d.header = 1'b1;
						end
						OFS_HEIGHT: begin
							if (dim_ok) height_d = word_next[DIM_W-1:0];
							else flags_d.header = 1'b1;
						end
						OFS_WIDTH: begin
							if (dim_ok) width_d = word_next[DIM_W-1:0];
							else flags_d.header = 1'b1;
						end
						OFS_PF_SIZE: begin
							if (word_next != PF_SIZE) flags_d.header = 1'b1;
						end
						OFS_PF_FLAGS: begin
							if ((word_next & PF_RGB) == 32'd0) flags_d.format = 1'b1;
							if ((word_next & PF_ALPHA) != 32'd0) flags_d.aflag = 1'b1;
						end
						OFS_BPP: begin
							if (word_next == BPP_32) four_d = 1'b1;
							else if (word_next != BPP_24) flags_d.depth = 1'b1;
						end
						OFS_RMASK: begin
							if (word_next != MASK_RED) flags_d.format = 1'b1;
						end
						OFS_GMASK: begin
							if (word_next != MASK_GREEN) flags_d.format = 1'b1;
						end
						OFS_BMASK: begin
							if (word_next != MASK_BLUE) flags_d.format = 1'b1;
						end
						OFS_AMASK: begin
							if (word_next == MASK_ALPHA) flags_d.amask = 1'b1;
						end
						default: ;
					endcase
				end
				if (pos_last) begin
					alpha_d = four_q && flags_q.aflag && flags_q.amask;
				end else begin
					hdr_pos_d = hdr_pos_q + 7'd1;
				end
			end
			PH_PIXELS: begin
				if (!need_last) begin
					case (idx_q)
						2'd0: pix_d[7:0]   = b;
						2'd1: pix_d[15:8]  = b;
						2'd2: pix_d[23:16] = b;
						default: pix_d = pix_q;
					endcase
					idx_d = idx_q + 2'd1;
				end else begin
					pix_d = '0;
					idx_d = '0;
					if (row_done) begin
						col_d = '0;
						row_d = row_inc;
					end else begin
						col_d = col_inc;
					end
				end
			end
			default: begin
				pix_d = pix_q;
			end
		endcase
		// Return to the reset state after every end of file
		if (eof) begin
			hdr_pos_d = '0;
			word_d    = '0;
			flags_d   = '0;
			width_d   = '0;
			height_d  = '0;
			four_d    = 1'b0;
			alpha_d   = 1'b0;
			pix_d     = '0;
			idx_d     = '0;
			col_d     = '0;
			row_d     = '0;
		end
	end

	// Advance state on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_pos_q <= '0;
			word_q    <= '0;
			flags_q   <= '0;
			width_q   <= '0;
			height_q  <= '0;
			four_q    <= 1'b0;
			alpha_q   <= 1'b0;
			pix_q     <= '0;
			idx_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_pos_q <= hdr_pos_d;
			word_q    <= word_d;
			flags_q   <= flags_d;
			width_q   <= width_d;
			height_q  <= height_d;
			four_q    <= four_d;
			alpha_q   <= alpha_d;
			pix_q     <= pix_d;
			idx_q     <= idx_d;
			col_q     <= col_d;
			row_q     <= row_d;
		end
	end

endmodule

// ===== rtl/dds_unp_premul.sv =====
// Alpha premultiply of three color lanes: c*a/255, truncated.
// Depends on dds_unp_pkg.
module dds_unp_premul
	import dds_unp_pkg::*;
(
	input  logic [23:0] color,
	input  logic [7:0]  alpha,
	output logic [7:0]  blue,
	output logic [7:0]  green,
	output logic [7:0]  red
);

	logic [7:0]  lane_in  [3];
	logic [7:0]  lane_out [3];
	logic [15:0] prod     [3];
	logic [16:0] adj      [3];

	assign lane_in[0] = color[7:0];
	assign lane_in[1] = color[15:8];
	assign lane_in[2] = color[23:16];

	// Divide by 255 as (p + p/256 + 1) / 256, exact for 16-bit products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i]     = {8'd0, lane_in[i]} * {8'd0, alpha};
			adj[i]      = {1'b0, prod[i]} + {9'd0, prod[i][15:8]} + 17'd1;
			lane_out[i] = adj[i][15:8];
		end
	end

	assign blue  = lane_out[0];
	assign green = lane_out[1];
	assign red   = lane_out[2];

endmodule
